### rtl/median_filter_3x3_clipped_unit_defines.svh
// Assertion macros for the clipped 3x3 median filter.
`ifndef MEDIAN_FILTER_3X3_CLIPPED_UNIT_DEFINES_SVH
`define MEDIAN_FILTER_3X3_CLIPPED_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MF3_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mf3 check failed");

// Next-cycle implication, checked out of reset.
`define MF3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mf3 check failed");

`endif

### rtl/mf3_pkg.sv
// Types, constants and the median selection function of the 3x3 median filter.
package mf3_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned ROW_W       = 16;
  localparam int unsigned COL_OUT_W   = 10;
  localparam int unsigned WIDTH_CFG_W = 11;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned OUT_DEPTH   = 4;
  localparam int unsigned OUT_PTR_W   = 2;
  localparam int unsigned OUT_CNT_W   = 3;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_CFG_W-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [ROW_W-1:0]       RESET_HEIGHT = 16'd480;

  typedef struct packed {
    logic             command;
    logic [PIX_W-1:0] pixel;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0]     median;
    logic [ROW_W-1:0]     out_row;
    logic [COL_OUT_W-1:0] out_col;
    logic                 last;
    logic                 frame_done;
  } out_t;

  // Window bytes, index row*3 + column; rows oldest first, columns oldest first.
  typedef logic [8:0][PIX_W-1:0] win_t;

  // Control carried from the input register to the result stage.
  typedef struct packed {
    logic                 shift;
    logic                 res_a;
    logic                 res_b;
    logic                 left_a;
    logic                 left_b;
    logic                 top;
    logic                 bot;
    logic                 last_a;
    logic                 done_b;
    logic                 par;
    logic [PIX_W-1:0]     pixel;
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col_a;
    logic [COL_OUT_W-1:0] col_b;
  } s1_t;

  typedef enum logic [2:0] {
    PR_NONE  = 3'b001,
    PR_HALF  = 3'b010,
    PR_READY = 3'b100
  } prime_e;

  // Median of the masked window entries; even counts average the middle pair.
  function automatic logic [PIX_W-1:0] median_sel(input win_t v, input logic [8:0] m);
    logic [3:0]       rank [9];
    logic [3:0]       n;
    logic [3:0]       half;
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
    logic [PIX_W:0]   sum;
    n  = 4'd0;
    lo = '0;
    hi = '0;
    for (int i = 0; i < 9; i++) begin
      n = n + 4'(m[i]);
    end
    for (int i = 0; i < 9; i++) begin
      rank[i] = 4'd0;
      for (int j = 0; j < 9; j++) begin
        if (m[j] && ((v[j] < v[i]) || ((v[j] == v[i]) && (j < i)))) begin
          rank[i] = rank[i] + 4'd1;
        end
      end
    end
    half = n >> 1;
    for (int i = 0; i < 9; i++) begin
      if (m[i] && (rank[i] == half)) hi = v[i];
      if (m[i] && (rank[i] == (half - 4'd1))) lo = v[i];
    end
    sum = {1'b0, lo} + {1'b0, hi};
    if (n[0]) begin
      return hi;
    end
    return sum[PIX_W:1];
  endfunction

endpackage

### rtl/mf3_line_store.sv
// Two row buffers, one per row parity, each with one write and one registered read.
module mf3_line_store import mf3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_i,
  input  logic                         wr_en_i,
  input  logic                         wr_bank_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr_i,
  input  logic [PIX_W-1:0]             wr_data_i,
  output logic [PIX_W-1:0]             rd_b0_o,
  output logic [PIX_W-1:0]             rd_b1_o
);

  logic [PIX_W-1:0] bank0 [MAX_WIDTH];
  logic [PIX_W-1:0] bank1 [MAX_WIDTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !wr_bank_i) begin
      bank0[wr_addr_i] <= wr_data_i;
    end
    rd_b0_o <= bank0[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_bank_i) begin
      bank1[wr_addr_i] <= wr_data_i;
    end
    rd_b1_o <= bank1[rd_addr_i];
  end

endmodule

### rtl/mf3_median.sv
// Clipped-window masks and the two median selectors of the result stage.
module mf3_median import mf3_pkg::*; (
  input  win_t win_i,
  input  s1_t  ctl_i,
  output out_t res_a_o,
  output out_t res_b_o
);

  logic [8:0] mask_a;
  logic [8:0] mask_b;

  // Result A is centered on the middle column, result B on the newest column.
  always_comb begin
    mask_a[0] = ctl_i.top & ctl_i.left_a;
    mask_a[1] = ctl_i.top;
    mask_a[2] = ctl_i.top;
    mask_a[3] = ctl_i.left_a;
    mask_a[4] = 1'b1;
    mask_a[5] = 1'b1;
    mask_a[6] = ctl_i.bot & ctl_i.left_a;
    mask_a[7] = ctl_i.bot;
    mask_a[8] = ctl_i.bot;

    mask_b[0] = 1'b0;
    mask_b[1] = ctl_i.top & ctl_i.left_b;
    mask_b[2] = ctl_i.top;
    mask_b[3] = 1'b0;
    mask_b[4] = ctl_i.left_b;
    mask_b[5] = 1'b1;
    mask_b[6] = 1'b0;
    mask_b[7] = ctl_i.bot & ctl_i.left_b;
    mask_b[8] = ctl_i.bot;
  end

  always_comb begin
    res_a_o.median     = median_sel(win_i, mask_a);
    res_a_o.out_row    = ctl_i.row;
    res_a_o.out_col    = ctl_i.col_a;
    res_a_o.last       = ctl_i.last_a;
    res_a_o.frame_done = 1'b0;

    res_b_o.median     = median_sel(win_i, mask_b);
    res_b_o.out_row    = ctl_i.row;
    res_b_o.out_col    = ctl_i.col_b;
    res_b_o.last       = 1'b1;
    res_b_o.frame_done = ctl_i.done_b;
  end

endmodule

### rtl/mf3_out_fifo.sv
// Result queue: takes up to two results a cycle, hands out one per transfer.
module mf3_out_fifo import mf3_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_a_i,
  input  logic                 push_b_i,
  input  out_t                 data_a_i,
  input  out_t                 data_b_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_o,
  output logic [OUT_CNT_W-1:0] count_o
);

  out_t                 mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_q, wr_d;
  logic [OUT_PTR_W-1:0] rd_q, rd_d;
  logic [OUT_CNT_W-1:0] cnt_q, cnt_d;
  logic                 pop;

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_o       = mem[rd_q];
  assign count_o     = cnt_q;

  always_comb begin
    wr_d  = wr_q + OUT_PTR_W'(push_a_i) + OUT_PTR_W'(push_b_i);
    rd_d  = rd_q + OUT_PTR_W'(pop);
    cnt_d = cnt_q + OUT_CNT_W'(push_a_i) + OUT_CNT_W'(push_b_i) - OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      mem[wr_q] <= data_a_i;
    end
    if (push_b_i) begin
      mem[wr_q + OUT_PTR_W'(push_a_i)] <= data_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### rtl/median_filter_3x3_clipped_unit.sv
// A result passes the input register and the result queue before it is offered.
// One input item per cycle while in_stall_o is low; a row-end pixel gives two
// results, which the single output port takes one by one from the 4-entry result queue.
// The first flush of an image is stalled while two columns are read from the line
// store ports into the window. Reset (async, active low) clears position,
// window and queue; the line store holds no reset and needs no clearing pass.
module median_filter_3x3_clipped_unit import mf3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

`include "median_filter_3x3_clipped_unit_defines.svh"

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned EW = (CW + 1 > WIDTH_CFG_W) ? CW + 1 : WIDTH_CFG_W;

  logic [WIDTH_CFG_W-1:0] cfg_w_q;
  logic [ROW_W-1:0]       cfg_h_q;
  logic [EW-1:0]          w_ext;
  logic [CW-1:0]          wm1;
  logic [ROW_W-1:0]       h_eff;

  logic [ROW_W-1:0] row_q;
  logic [CW-1:0]    col_q;
  logic [CW-1:0]    flush_q;
  logic [CW-1:0]    fc;
  logic             f_done;
  logic             in_img;
  logic             last_col;

  prime_e prime_q, prime_d;
  logic   prime_req;
  logic   space_ok;
  logic   acc;
  logic   acc_pix;
  logic   acc_flush;

  logic [CW-1:0]    rd_addr;
  logic [PIX_W-1:0] rd_b0;
  logic [PIX_W-1:0] rd_b1;
  logic [PIX_W-1:0] row0_px;
  logic [PIX_W-1:0] row1_px;

  s1_t  s1_q, s1_d;
  win_t win_q, win_new;
  out_t res_a;
  out_t res_b;
  logic [1:0]           s1_nres;
  logic [OUT_CNT_W-1:0] fifo_cnt;

  // Effective geometry: zero counts as one, width saturates at the buffer size.
  always_comb begin
    w_ext = EW'(cfg_w_q);
    if (w_ext == '0) w_ext = EW'(1);
    if (w_ext > EW'(MAX_WIDTH)) w_ext = EW'(MAX_WIDTH);
    wm1   = CW'(w_ext - EW'(1));
    h_eff = (cfg_h_q == '0) ? ROW_W'(1) : cfg_h_q;
  end

  assign fc       = (flush_q > wm1) ? wm1 : flush_q;
  assign f_done   = (fc == wm1);
  assign in_img   = (row_q < h_eff);
  assign last_col = (col_q >= wm1);

  assign prime_req = in_valid_i && (in_i.command == CMD_FLUSH) && !in_img &&
                     (prime_q != PR_READY);
  assign s1_nres   = {1'b0, s1_q.res_a} + {1'b0, s1_q.res_b};
  assign space_ok  = ({1'b0, fifo_cnt} + {2'b00, s1_nres}) <= 4'd2;
  assign in_stall_o = !space_ok || prime_req;
  assign acc       = in_valid_i && !in_stall_o;
  assign acc_pix   = acc && (in_i.command == CMD_PIXEL) && in_img;
  assign acc_flush = acc && (in_i.command == CMD_FLUSH) && !in_img;

  // Flush reads one column ahead; priming loads the two columns left of it.
  always_comb begin
    if (prime_req) begin
      if (prime_q == PR_NONE) begin
        rd_addr = (fc != '0) ? fc - CW'(1) : fc;
      end else begin
        rd_addr = fc;
      end
    end else if (in_i.command == CMD_PIXEL) begin
      rd_addr = col_q;
    end else begin
      rd_addr = f_done ? fc : fc + CW'(1);
    end
  end

  always_comb begin
    s1_d       = '0;
    // Flush reads the last row pair, whose parity follows the image height.
    s1_d.par   = in_img ? row_q[0] : h_eff[0];
    s1_d.pixel = in_i.pixel;
    if (prime_req) begin
      s1_d.shift = 1'b1;
    end else if (acc_pix) begin
      s1_d.shift  = 1'b1;
      s1_d.res_a  = (row_q != '0) && (col_q != '0);
      s1_d.res_b  = (row_q != '0) && last_col;
      s1_d.left_a = (col_q >= CW'(2));
      s1_d.left_b = (col_q != '0);
      s1_d.top    = (row_q >= ROW_W'(2));
      s1_d.bot    = 1'b1;
      s1_d.last_a = !last_col;
      s1_d.row    = row_q - ROW_W'(1);
      s1_d.col_a  = COL_OUT_W'(col_q - CW'(1));
      s1_d.col_b  = COL_OUT_W'(col_q);
    end else if (acc_flush) begin
      s1_d.shift  = !f_done;
      s1_d.res_a  = !f_done;
      s1_d.res_b  = f_done;
      s1_d.left_a = (fc != '0);
      s1_d.left_b = (fc != '0);
      s1_d.top    = (h_eff >= ROW_W'(2));
      s1_d.last_a = 1'b1;
      s1_d.done_b = 1'b1;
      s1_d.row    = h_eff - ROW_W'(1);
      s1_d.col_a  = COL_OUT_W'(fc);
      s1_d.col_b  = COL_OUT_W'(fc);
    end
  end

  always_comb begin
    prime_d = prime_q;
    unique case (prime_q)
      PR_NONE:  if (prime_req) prime_d = PR_HALF;
      PR_HALF:  if (prime_req) prime_d = PR_READY;
      PR_READY: prime_d = PR_READY;
      default:  prime_d = PR_NONE;
    endcase
    if (cfg_we_i || acc_pix || (acc_flush && f_done)) begin
      prime_d = PR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= RESET_WIDTH;
      cfg_h_q <= RESET_HEIGHT;
      row_q   <= '0;
      col_q   <= '0;
      flush_q <= '0;
      prime_q <= PR_NONE;
      s1_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_IMAGE_WIDTH:  cfg_w_q <= cfg_wdata_i[WIDTH_CFG_W-1:0];
          REG_IMAGE_HEIGHT: cfg_h_q <= cfg_wdata_i[ROW_W-1:0];
          default: ;
        endcase
      end
      if (acc_pix) begin
        if (last_col) begin
          col_q <= '0;
          row_q <= row_q + ROW_W'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end else if (acc_flush) begin
        if (f_done) begin
          row_q   <= '0;
          col_q   <= '0;
          flush_q <= '0;
        end else begin
          flush_q <= fc + CW'(1);
        end
      end
      prime_q <= prime_d;
      s1_q    <= s1_d;
    end
  end

  mf3_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .wr_en_i   (acc_pix),
    .wr_bank_i (row_q[0]),
    .wr_addr_i (col_q),
    .wr_data_i (in_i.pixel),
    .rd_b0_o   (rd_b0),
    .rd_b1_o   (rd_b1)
  );

  // Bank of the current row parity holds two rows back, the other one row back.
  assign row0_px = s1_q.par ? rd_b1 : rd_b0;
  assign row1_px = s1_q.par ? rd_b0 : rd_b1;

  always_comb begin
    win_new = win_q;
    if (s1_q.shift) begin
      win_new[0] = win_q[1];
      win_new[1] = win_q[2];
      win_new[2] = row0_px;
      win_new[3] = win_q[4];
      win_new[4] = win_q[5];
      win_new[5] = row1_px;
      win_new[6] = win_q[7];
      win_new[7] = win_q[8];
      win_new[8] = s1_q.pixel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_new;
    end
  end

  mf3_median u_median (
    .win_i   (win_new),
    .ctl_i   (s1_q),
    .res_a_o (res_a),
    .res_b_o (res_b)
  );

  mf3_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_a_i    (s1_q.res_a),
    .push_b_i    (s1_q.res_b),
    .data_a_i    (res_a),
    .data_b_i    (res_b),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .count_o     (fifo_cnt)
  );

  `MF3_ASSERT_NOW(a_fifo_bound, 1'b1, fifo_cnt <= OUT_CNT_W'(OUT_DEPTH))
  `MF3_ASSERT_NOW(a_flush_primed, acc_flush, prime_q == PR_READY)
  `MF3_ASSERT_NEXT(a_pix_enters, acc_pix, s1_q.shift)
  `MF3_ASSERT_NOW(a_done_is_last, out_valid_o && out_o.frame_done, out_o.last)

endmodule
